// File: design/cna_pkg.sv
`default_nettype none
package cna_pkg;

  // Parameter defaults
  localparam int DATA_WIDTH_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // Fixed result format and fixed-point constants
  localparam int OUT_W        = 25;
  localparam int FRAC_W       = 8;
  localparam int CORDIC_FRAC  = 16;
  localparam int Q8_BIAS      = 255;
  localparam int DEG90_Q8     = 23040;
  localparam int ZW           = 24;
  localparam int ATAN_N       = 24;
  localparam int FRONT_STAGES = 3;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_MUL  = 3'd1,
    CMD_CONJ = 3'd2,
    CMD_MOD  = 3'd3,
    CMD_ARG  = 3'd4
  } cmd_e;

  // Control and finished simple results that ride along the cell row
  typedef struct packed {
    logic [2:0]       cmd;
    logic [OUT_W-1:0] res_re;
    logic [OUT_W-1:0] res_im;
    logic             re_zero;
    logic             im_pos;
    logic             im_neg;
  } ctl_t;

  // atan(2^-i) in degrees, Q.16, rounded to nearest
  function automatic logic [ZW-1:0] atan_deg(input logic [4:0] idx);
    logic [ZW-1:0] val;
    case (idx)
      5'd0:    val = 24'd2949120;
      5'd1:    val = 24'd1740967;
      5'd2:    val = 24'd919879;
      5'd3:    val = 24'd466945;
      5'd4:    val = 24'd234379;
      5'd5:    val = 24'd117304;
      5'd6:    val = 24'd58666;
      5'd7:    val = 24'd29335;
      5'd8:    val = 24'd14668;
      5'd9:    val = 24'd7334;
      5'd10:   val = 24'd3667;
      5'd11:   val = 24'd1833;
      5'd12:   val = 24'd917;
      5'd13:   val = 24'd458;
      5'd14:   val = 24'd229;
      5'd15:   val = 24'd115;
      5'd16:   val = 24'd57;
      5'd17:   val = 24'd29;
      5'd18:   val = 24'd14;
      5'd19:   val = 24'd7;
      5'd20:   val = 24'd4;
      5'd21:   val = 24'd2;
      5'd22:   val = 24'd1;
      default: val = 24'd0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// File: design/cna_front.sv
`default_nettype none
module cna_front #(
  parameter int DW = cna_pkg::DATA_WIDTH_DEF
) (
  input  wire                                  clk_i,
  input  wire  [cna_pkg::FRONT_STAGES-1:0]     en_i,
  input  wire  [2:0]                           cmd_i,
  input  wire  signed [DW-1:0]                 a_re_i,
  input  wire  signed [DW-1:0]                 a_im_i,
  input  wire  signed [DW-1:0]                 b_re_i,
  input  wire  signed [DW-1:0]                 b_im_i,
  output cna_pkg::ctl_t                        ctl_o,
  output logic signed [DW+18:0]                x_o,
  output logic signed [DW+18:0]                y_o,
  output logic [2*DW-1:0]                      rad_o
);

  localparam int PW    = 2 * DW;
  localparam int XW    = DW + 19;
  localparam int OW    = cna_pkg::OUT_W;
  localparam int FW    = cna_pkg::FRAC_W;
  localparam int EXT_W = (2 * DW + 2 > OW + FW) ? 2 * DW + 2 : OW + FW;

  // Stage A: products, add/conjugate results, CORDIC start vector
  logic signed [EXT_W-1:0] add_re, add_im, neg_im;
  logic signed [DW:0]      re_w, im_w, re_n, im_n;
  logic [OW-1:0]           simp_re_d, simp_im_d;
  logic signed [PW-1:0]    p_rr_d, p_ii_d, p_ri_d, p_ir_d, sq_r_d, sq_i_d;

  logic [2:0]              cmd_a_q;
  logic [OW-1:0]           simp_re_a_q, simp_im_a_q;
  logic signed [PW-1:0]    p_rr_a_q, p_ii_a_q, p_ri_a_q, p_ir_a_q, sq_r_a_q, sq_i_a_q;
  logic signed [XW-1:0]    x_a_q, y_a_q;
  logic                    re_zero_a_q, im_pos_a_q, im_neg_a_q;

  assign add_re = EXT_W'(a_re_i) + EXT_W'(b_re_i);
  assign add_im = EXT_W'(a_im_i) + EXT_W'(b_im_i);
  assign neg_im = EXT_W'(0) - EXT_W'(a_im_i);

  assign p_rr_d = a_re_i * b_re_i;
  assign p_ii_d = a_im_i * b_im_i;
  assign p_ri_d = a_re_i * b_im_i;
  assign p_ir_d = a_im_i * b_re_i;
  assign sq_r_d = a_re_i * a_re_i;
  assign sq_i_d = a_im_i * a_im_i;

  assign re_w = (DW+1)'(a_re_i);
  assign im_w = (DW+1)'(a_im_i);
  // Fold the left half-plane over; atan(im/re) is unchanged
  assign re_n = a_re_i[DW-1] ? -re_w : re_w;
  assign im_n = a_re_i[DW-1] ? -im_w : im_w;

  always_comb begin
    case (cna_pkg::cmd_e'(cmd_i))
      cna_pkg::CMD_ADD: begin
        simp_re_d = add_re[OW-1:0];
        simp_im_d = add_im[OW-1:0];
      end
      cna_pkg::CMD_CONJ: begin
        simp_re_d = OW'(a_re_i);
        simp_im_d = neg_im[OW-1:0];
      end
      default: begin
        simp_re_d = '0;
        simp_im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cmd_a_q     <= cmd_i;
      simp_re_a_q <= simp_re_d;
      simp_im_a_q <= simp_im_d;
      p_rr_a_q    <= p_rr_d;
      p_ii_a_q    <= p_ii_d;
      p_ri_a_q    <= p_ri_d;
      p_ir_a_q    <= p_ir_d;
      sq_r_a_q    <= sq_r_d;
      sq_i_a_q    <= sq_i_d;
      x_a_q       <= XW'(re_n) <<< cna_pkg::CORDIC_FRAC;
      y_a_q       <= XW'(im_n) <<< cna_pkg::CORDIC_FRAC;
      re_zero_a_q <= (a_re_i == '0);
      im_pos_a_q  <= !a_im_i[DW-1] && (a_im_i != '0);
      im_neg_a_q  <= a_im_i[DW-1];
    end
  end

  // Stage B: complex product sums and modulus radicand
  logic signed [EXT_W-1:0] mre_d, mim_d;
  logic [PW-1:0]           rad_d;

  logic [2:0]              cmd_b_q;
  logic [OW-1:0]           simp_re_b_q, simp_im_b_q;
  logic signed [EXT_W-1:0] mre_b_q, mim_b_q;
  logic [PW-1:0]           rad_b_q;
  logic signed [XW-1:0]    x_b_q, y_b_q;
  logic                    re_zero_b_q, im_pos_b_q, im_neg_b_q;

  assign mre_d = EXT_W'(p_rr_a_q) - EXT_W'(p_ii_a_q);
  assign mim_d = EXT_W'(p_ri_a_q) + EXT_W'(p_ir_a_q);
  assign rad_d = $unsigned(sq_r_a_q) + $unsigned(sq_i_a_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      cmd_b_q     <= cmd_a_q;
      simp_re_b_q <= simp_re_a_q;
      simp_im_b_q <= simp_im_a_q;
      mre_b_q     <= mre_d;
      mim_b_q     <= mim_d;
      rad_b_q     <= rad_d;
      x_b_q       <= x_a_q;
      y_b_q       <= y_a_q;
      re_zero_b_q <= re_zero_a_q;
      im_pos_b_q  <= im_pos_a_q;
      im_neg_b_q  <= im_neg_a_q;
    end
  end

  // Stage C: drop 8 fraction bits of the product toward zero, pick the product or the simple result
  logic signed [EXT_W-1:0] mre_t, mim_t;
  cna_pkg::ctl_t           ctl_d;

  assign mre_t = mre_b_q + (mre_b_q[EXT_W-1] ? EXT_W'(cna_pkg::Q8_BIAS) : EXT_W'(0));
  assign mim_t = mim_b_q + (mim_b_q[EXT_W-1] ? EXT_W'(cna_pkg::Q8_BIAS) : EXT_W'(0));

  always_comb begin
    ctl_d.cmd     = cmd_b_q;
    ctl_d.re_zero = re_zero_b_q;
    ctl_d.im_pos  = im_pos_b_q;
    ctl_d.im_neg  = im_neg_b_q;
    if (cna_pkg::cmd_e'(cmd_b_q) == cna_pkg::CMD_MUL) begin
      ctl_d.res_re = mre_t[OW+FW-1:FW];
      ctl_d.res_im = mim_t[OW+FW-1:FW];
    end else begin
      ctl_d.res_re = simp_re_b_q;
      ctl_d.res_im = simp_im_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      ctl_o <= ctl_d;
      x_o   <= x_b_q;
      y_o   <= y_b_q;
      rad_o <= rad_b_q;
    end
  end

endmodule
`default_nettype wire

// File: design/cna_cell.sv
`default_nettype none
module cna_cell #(
  parameter int DW  = cna_pkg::DATA_WIDTH_DEF,
  parameter int CS  = cna_pkg::CORDIC_STEPS_DEF,
  parameter int IDX = 0
) (
  input  wire                                 clk_i,
  input  wire                                 en_i,
  input  cna_pkg::ctl_t                       ctl_i,
  input  wire  signed [DW+18:0]               x_i,
  input  wire  signed [DW+18:0]               y_i,
  input  wire  signed [cna_pkg::ZW-1:0]       z_i,
  input  wire  [2*DW-1:0]                     rem_i,
  input  wire  [DW-1:0]                       root_i,
  output cna_pkg::ctl_t                       ctl_o,
  output logic signed [DW+18:0]               x_o,
  output logic signed [DW+18:0]               y_o,
  output logic signed [cna_pkg::ZW-1:0]       z_o,
  output logic [2*DW-1:0]                     rem_o,
  output logic [DW-1:0]                       root_o
);

  localparam int XW = DW + 19;
  localparam int ZW = cna_pkg::ZW;
  localparam int RW = 2 * DW + 1;

  logic signed [XW-1:0] x_d, y_d;
  logic signed [ZW-1:0] z_d;
  logic [2*DW-1:0]      rem_d;
  logic [DW-1:0]        root_d;

  // One CORDIC vectoring micro-rotation, or a pass-through past the last step
  if (IDX < CS) begin : g_rot
    localparam logic signed [ZW-1:0] ATAN_I = cna_pkg::atan_deg(5'(IDX));
    logic signed [XW-1:0] dx, dy;
    assign dx = y_i >>> IDX;
    assign dy = x_i >>> IDX;
    always_comb begin
      if (!y_i[XW-1]) begin
        x_d = x_i + dx;
        y_d = y_i - dy;
        z_d = z_i + ATAN_I;
      end else begin
        x_d = x_i - dx;
        y_d = y_i + dy;
        z_d = z_i - ATAN_I;
      end
    end
  end else begin : g_rot_pass
    assign x_d = x_i;
    assign y_d = y_i;
    assign z_d = z_i;
  end

  // One root bit of the restoring square root, or a pass-through past the last bit
  if (IDX < DW) begin : g_sqrt
    localparam int K = DW - 1 - IDX;
    logic [RW-1:0] trial;
    logic          take;
    assign trial = (RW'(root_i) << (K + 1)) | (RW'(1) << (2 * K));
    assign take  = RW'(rem_i) >= trial;
    assign rem_d  = take ? rem_i - trial[2*DW-1:0] : rem_i;
    assign root_d = take ? (root_i | (DW'(1) << K)) : root_i;
  end else begin : g_sqrt_pass
    assign rem_d  = rem_i;
    assign root_d = root_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o  <= ctl_i;
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      rem_o  <= rem_d;
      root_o <= root_d;
    end
  end

endmodule
`default_nettype wire

// File: design/cna_out.sv
`default_nettype none
module cna_out #(
  parameter int DW = cna_pkg::DATA_WIDTH_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  en_i,
  input  cna_pkg::ctl_t                        ctl_i,
  input  wire  signed [cna_pkg::ZW-1:0]        z_i,
  input  wire  [DW-1:0]                        root_i,
  output logic signed [cna_pkg::OUT_W-1:0]     res_re_o,
  output logic signed [cna_pkg::OUT_W-1:0]     res_im_o
);

  localparam int ZW = cna_pkg::ZW;
  localparam int FW = cna_pkg::FRAC_W;
  localparam int QW = ZW - FW;
  localparam int OW = cna_pkg::OUT_W;
  localparam logic signed [QW-1:0] D90 = QW'(cna_pkg::DEG90_Q8);

  logic signed [ZW-1:0] z_t;
  logic signed [QW-1:0] q, arg;
  logic [OW-1:0]        re_d, im_d;

  // Degrees Q.16 to Q.8, toward zero, then clamp to +-90; a zero real part gives +-90 or 0
  assign z_t = z_i + (z_i[ZW-1] ? ZW'(cna_pkg::Q8_BIAS) : ZW'(0));
  assign q   = z_t[ZW-1:FW];

  always_comb begin
    if (ctl_i.re_zero) begin
      if (ctl_i.im_pos) begin
        arg = D90;
      end else if (ctl_i.im_neg) begin
        arg = -D90;
      end else begin
        arg = '0;
      end
    end else if (q > D90) begin
      arg = D90;
    end else if (q < -D90) begin
      arg = -D90;
    end else begin
      arg = q;
    end
  end

  always_comb begin
    case (cna_pkg::cmd_e'(ctl_i.cmd))
      cna_pkg::CMD_ADD, cna_pkg::CMD_MUL, cna_pkg::CMD_CONJ: begin
        re_d = ctl_i.res_re;
        im_d = ctl_i.res_im;
      end
      cna_pkg::CMD_MOD: begin
        re_d = OW'(root_i);
        im_d = '0;
      end
      cna_pkg::CMD_ARG: begin
        re_d = OW'(arg);
        im_d = '0;
      end
      default: begin
        re_d = '0;
        im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_re_o <= re_d;
      res_im_o <= im_d;
    end
  end

endmodule
`default_nettype wire

// File: design/complex_number_alu.sv
// Stages: three front stages, one cell per CORDIC step or root bit (whichever is
// more), one output stage. Each cell retires at most one CORDIC step and one root bit.
// Throughput: one item per cycle unless a stalled output backs up the full row.
// Each stage moves on when it or any later stage holds a bubble, so a stalled result
// does not block new items from filling the row.
// Reset: asynchronous, active low; clears all stage valid flags, data is not cleared.
`default_nettype none
module complex_number_alu #(
  parameter int DATA_WIDTH   = cna_pkg::DATA_WIDTH_DEF,
  parameter int CORDIC_STEPS = cna_pkg::CORDIC_STEPS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire  [2:0]                           cmd_i,
  input  wire  signed [DATA_WIDTH-1:0]         a_re_i,
  input  wire  signed [DATA_WIDTH-1:0]         a_im_i,
  input  wire  signed [DATA_WIDTH-1:0]         b_re_i,
  input  wire  signed [DATA_WIDTH-1:0]         b_im_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic signed [cna_pkg::OUT_W-1:0]     res_re_o,
  output logic signed [cna_pkg::OUT_W-1:0]     res_im_o
);

  localparam int DW    = DATA_WIDTH;
  localparam int XW    = DW + 19;
  localparam int ZW    = cna_pkg::ZW;
  localparam int FS    = cna_pkg::FRONT_STAGES;
  // One cell per CORDIC step and per root bit, whichever is more
  localparam int NCELL = (DATA_WIDTH > CORDIC_STEPS) ? DATA_WIDTH : CORDIC_STEPS;
  localparam int NS    = FS + NCELL + 1;

  // Per-stage valid flags and load enables
  logic [NS-1:0] valid_q, valid_d;
  logic [NS-1:0] en;

  // A stage may load when it or some later stage up to the output is empty, or the
  // output item is being taken this cycle
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = out_ready_i || !(&valid_q[NS-1:k]);
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NS-1];

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Chain links: index 0 feeds the first cell, index NCELL leaves the last
  cna_pkg::ctl_t        ctl_c  [NCELL+1];
  logic signed [XW-1:0] x_c    [NCELL+1];
  logic signed [XW-1:0] y_c    [NCELL+1];
  logic signed [ZW-1:0] z_c    [NCELL+1];
  logic [2*DW-1:0]      rem_c  [NCELL+1];
  logic [DW-1:0]        root_c [NCELL+1];

  // Front: products, sums, toward-zero scaling, CORDIC start vector
  cna_front #(
    .DW (DW)
  ) u_front (
    .clk_i  (clk_i),
    .en_i   (en[FS-1:0]),
    .cmd_i  (cmd_i),
    .a_re_i (a_re_i),
    .a_im_i (a_im_i),
    .b_re_i (b_re_i),
    .b_im_i (b_im_i),
    .ctl_o  (ctl_c[0]),
    .x_o    (x_c[0]),
    .y_o    (y_c[0]),
    .rad_o  (rem_c[0])
  );

  // Start the angle at zero and the root with no bits set
  assign z_c[0]    = '0;
  assign root_c[0] = '0;

  // Row of cells: each advances the CORDIC rotation and the square root by at most one step
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cna_cell #(
      .DW  (DW),
      .CS  (CORDIC_STEPS),
      .IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en[FS+i]),
      .ctl_i  (ctl_c[i]),
      .x_i    (x_c[i]),
      .y_i    (y_c[i]),
      .z_i    (z_c[i]),
      .rem_i  (rem_c[i]),
      .root_i (root_c[i]),
      .ctl_o  (ctl_c[i+1]),
      .x_o    (x_c[i+1]),
      .y_o    (y_c[i+1]),
      .z_o    (z_c[i+1]),
      .rem_o  (rem_c[i+1]),
      .root_o (root_c[i+1])
    );
  end

  // Output register: pick the result for the item's operation and hold it
  // until the consumer takes it
  cna_out #(
    .DW (DW)
  ) u_out (
    .clk_i    (clk_i),
    .en_i     (en[NS-1]),
    .ctl_i    (ctl_c[NCELL]),
    .z_i      (z_c[NCELL]),
    .root_i   (root_c[NCELL]),
    .res_re_o (res_re_o),
    .res_im_o (res_im_o)
  );

endmodule
`default_nettype wire

// File: tb/complex_number_alu_tb.sv
`default_nettype none
module complex_number_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cna_pkg::*;

  localparam int HALF_NS      = 1;
  localparam int RESET_CYCLES = 9;
  localparam int DW           = DATA_WIDTH_DEF;
  localparam int STEPS        = CORDIC_STEPS_DEF;
  localparam int RAND_ITEMS   = 1400;
  localparam int MAX_IDLE     = 10;
  // Pipeline depth is 4 + max(DATA_WIDTH, CORDIC_STEPS); drain a generous margin past it.
  localparam int DRAIN_CYCLES = 4 * (4 + ((DW > STEPS) ? DW : STEPS));
  // Long receiver hold-off, started once after this many results have come out.
  localparam int HOLD_AT      = 300;
  localparam int HOLD_LEN     = 400;
  // Quiet cycles (no item moving on either side) before the run is declared hung.
  localparam int QUIET_LIMIT  = 5000;

  localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [2:0]           CMD_TOP = '1;
  localparam longint               Q8_DIV  = longint'(1) << FRAC_W;

  typedef struct packed {
    logic [2:0]           cmd;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
    logic [3:0]           idle;
  } alu_op_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
  } alu_res_t;

  // atan(2^-i) in degrees, Q.16, rounded to nearest
  longint atan_q16 [0:ATAN_N-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic [2:0]              cmd_i       = CMD_ADD;
  logic signed [DW-1:0]    a_re_i      = '0;
  logic signed [DW-1:0]    a_im_i      = '0;
  logic signed [DW-1:0]    b_re_i      = '0;
  logic signed [DW-1:0]    b_im_i      = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] res_re_o;
  logic signed [OUT_W-1:0] res_im_o;

  alu_op_t  pending_ops [$];
  alu_res_t expected_res [$];
  alu_op_t  cur_op;
  int       idle_cnt     = 0;
  int       stall_left   = 0;
  int       res_seen     = 0;
  int       hold_left    = 0;
  bit       hold_done    = 1'b0;
  int       quiet_cnt    = 0;
  int       mismatch_cnt = 0;
  int       queued_cnt   = 0;

  complex_number_alu DUT (.*);

  always #HALF_NS clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: integer square root, CORDIC argument and the per-command result
  // ---------------------------------------------------------------------------

  // floor(sqrt(n)) for a non-negative n, one result bit per pass
  function automatic longint root_floor(longint n);
    longint r, probe;
    r = 0;
    probe = longint'(1) << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= r + probe) begin
        n = n - (r + probe);
        r = (r >> 1) + probe;
      end else begin
        r = r >> 1;
      end
      probe = probe >> 2;
    end
    return r;
  endfunction

  // atan(im/re) in degrees Q.8, folded into the right half plane, no quadrant fix
  function automatic longint angle_q8(longint re, longint im);
    longint x, y, z, dx, dy, q;
    if (re == 0) begin
      if (im > 0) return DEG90_Q8;
      if (im < 0) return -DEG90_Q8;
      return 0;
    end
    // Negating both parts keeps the ratio and puts x on the positive side
    if (re < 0) begin
      re = -re;
      im = -im;
    end
    x = re <<< CORDIC_FRAC;
    y = im <<< CORDIC_FRAC;
    z = 0;
    for (int i = 0; i < STEPS && i < ATAN_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_q16[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_q16[i];
      end
    end
    q = z / Q8_DIV;
    if (q > DEG90_Q8) q = DEG90_Q8;
    if (q < -DEG90_Q8) q = -DEG90_Q8;
    return q;
  endfunction

  function automatic alu_res_t complex_result(alu_op_t op);
    longint   ar, ai, br, bi, rr, ri;
    alu_res_t res;
    ar = op.a_re;
    ai = op.a_im;
    br = op.b_re;
    bi = op.b_im;
    rr = 0;
    ri = 0;
    case (op.cmd)
      CMD_ADD: begin
        rr = ar + br;
        ri = ai + bi;
      end
      CMD_MUL: begin
        // Full complex product in Q.16, back to Q.8 truncating toward zero
        rr = (ar * br - ai * bi) / Q8_DIV;
        ri = (ar * bi + ai * br) / Q8_DIV;
      end
      CMD_CONJ: begin
        rr = ar;
        ri = -ai;
      end
      CMD_MOD:  rr = root_floor(ar * ar + ai * ai);
      CMD_ARG:  rr = angle_q8(ar, ai);
      default: ;  // unused codes give a zero result
    endcase
    res.re = rr[OUT_W-1:0];
    res.im = ri[OUT_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  // Lean on the edges: extremes, zero and tiny values, otherwise any pattern
  function automatic logic signed [DW-1:0] draw_operand();
    logic signed [DW-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = S_MIN;
      1:       v = S_MAX;
      2:       v = '0;
      3:       v = DW'($signed($urandom_range(0, 16)) - 8);
      default: v = DW'($urandom);
    endcase
    return v;
  endfunction

  // Queue one item; every third block of 150 items goes back to back
  task automatic queue_op(input logic [2:0] cmd, input logic signed [DW-1:0] ar,
                          input logic signed [DW-1:0] ai, input logic signed [DW-1:0] br,
                          input logic signed [DW-1:0] bi);
    alu_op_t op;
    op.cmd  = cmd;
    op.a_re = ar;
    op.a_im = ai;
    op.b_re = br;
    op.b_im = bi;
    op.idle = ((queued_cnt / 150) % 3 == 1) ? 4'd0 : 4'($urandom_range(0, MAX_IDLE));
    pending_ops.push_back(op);
    queued_cnt++;
  endtask

  initial begin
    logic [2:0] cmd;
    // Directed items: field extremes, every command and the corner cases
    queue_op(CMD_ADD,  S_MAX, S_MAX, S_MAX, S_MAX);
    queue_op(CMD_ADD,  S_MIN, S_MIN, S_MIN, S_MIN);
    queue_op(CMD_MUL,  S_MIN, S_MIN, S_MIN, S_MIN);
    queue_op(CMD_MUL,  S_MAX, S_MIN, S_MIN, S_MAX);
    // negative product below one LSB truncates to zero, not to -1
    queue_op(CMD_MUL,  1, 0, -1, 0);
    queue_op(CMD_MUL,  3, -5, 7, 11);
    queue_op(CMD_CONJ, S_MIN, S_MIN, S_MAX, S_MAX);
    queue_op(CMD_CONJ, S_MAX, 0, S_MIN, S_MIN);
    queue_op(CMD_MOD,  S_MIN, S_MIN, S_MAX, S_MAX);
    queue_op(CMD_MOD,  0, 0, S_MIN, S_MIN);
    queue_op(CMD_MOD,  S_MAX, S_MAX, 0, 0);
    // zero real part: +90, -90, and zero when both parts vanish
    queue_op(CMD_ARG,  0, S_MAX, 0, 0);
    queue_op(CMD_ARG,  0, S_MIN, 0, 0);
    queue_op(CMD_ARG,  0, 0, S_MAX, S_MAX);
    // negative real part folds into the right half plane
    queue_op(CMD_ARG,  S_MIN, S_MIN, 0, 0);
    queue_op(CMD_ARG,  1, S_MAX, 0, 0);
    queue_op(CMD_ARG,  -1, S_MAX, 0, 0);
    queue_op(CMD_ARG,  S_MAX, 0, 0, 0);
    queue_op(CMD_ARG,  -256, 256, 0, 0);
    // unused command codes return zero
    queue_op(3'(CMD_ARG + 1), S_MAX, S_MIN, S_MAX, S_MIN);
    queue_op(3'(CMD_ARG + 2), S_MIN, S_MAX, S_MIN, S_MAX);
    queue_op(CMD_TOP, -1, -1, -1, -1);

    // Random items, mostly real commands with a sprinkling of unused codes
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if ($urandom_range(0, 19) < 18) cmd = 3'($urandom_range(CMD_ADD, CMD_ARG));
      else cmd = 3'($urandom_range(CMD_ARG + 1, CMD_TOP));
      queue_op(cmd, draw_operand(), draw_operand(), draw_operand(), draw_operand());
    end

    // Hold reset, then release on a clock edge
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last item to go in and the last result to come out
    while (pending_ops.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_res.size() != 0) @(posedge clk_i);
    // Let any stray result surface before calling it
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_res.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: present items from the pending queue, idle between them
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      idle_cnt   <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      // Item taken at this edge: record what it must produce
      if (in_valid_i) expected_res.push_back(complex_result(cur_op));
      if (pending_ops.size() != 0 && idle_cnt >= pending_ops[0].idle) begin
        cur_op     <= pending_ops[0];
        cmd_i      <= pending_ops[0].cmd;
        a_re_i     <= pending_ops[0].a_re;
        a_im_i     <= pending_ops[0].a_im;
        b_re_i     <= pending_ops[0].b_re;
        b_im_i     <= pending_ops[0].b_im;
        in_valid_i <= 1'b1;
        idle_cnt   <= 0;
        void'(pending_ops.pop_front());
      end else begin
        // Drop valid and count out this item's idle gap
        in_valid_i <= 1'b0;
        if (pending_ops.size() != 0) idle_cnt <= idle_cnt + 1;
      end
    end
    // otherwise hold valid and payload until the block takes the item
  end

  // ---------------------------------------------------------------------------
  // Long hold-off: stop taking results once so the pipeline backs up
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && res_seen >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result against the oldest expectation, stall at random
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : mon_blk
    alu_res_t want;
    int       stall;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
      res_seen    <= 0;
    end else begin
      stall = stall_left;
      if (out_valid_o && out_ready_i) begin
        res_seen <= res_seen + 1;
        if (expected_res.size() == 0) begin
          $error("unexpected result: res_re=%0d res_im=%0d", res_re_o, res_im_o);
          mismatch_cnt++;
        end else begin
          want = expected_res.pop_front();
          if (res_re_o !== want.re) begin
            $error("res_re mismatch: expected %0d, got %0d", want.re, res_re_o);
            mismatch_cnt++;
          end
          if (res_im_o !== want.im) begin
            $error("res_im mismatch: expected %0d, got %0d", want.im, res_im_o);
            mismatch_cnt++;
          end
        end
        // Every third block of 128 results runs without stalls
        stall = ((res_seen / 128) % 3 == 0) ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
      end else if (stall != 0) begin
        out_ready_i <= 1'b0;
        stall = stall - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
      stall_left <= stall;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if nothing moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

endmodule
`default_nettype wire
